@@ hw/rtl/axfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axfp_pkg
// Shared types, constants and digit arithmetic for the ascii xy frame parser.
// ----------------------------------------------------------------------------
package axfp_pkg;

	localparam int GroupLen   = 5;
	localparam int IdxW       = 3;
	localparam int ByteW      = 8;
	localparam int PosW       = 19;
	localparam int LoW        = 13;
	localparam int CfgIdxW    = 1;
	localparam int QueueDepth = 2;

	localparam logic [ByteW-1:0] HeaderReset  = 8'hCC;
	localparam logic [ByteW-1:0] TrailerReset = 8'hDD;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HEADER  = 1'b0,
		CFG_TRAILER = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_X     = 2'd1,
		PH_Y     = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	// digits used per value: chars 0, 2, 3, 4 (char 1 carries no weight)
	typedef struct packed {
		logic [3:0][ByteW-1:0] x_dig;
		logic [3:0][ByteW-1:0] y_dig;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} push_t;

	// thousands and hundreds part: (c0-48)*1000 + (c2-48)*100
	function automatic logic signed [PosW-1:0] hi_part(input logic [ByteW-1:0] c0,
			input logic [ByteW-1:0] c2);
		logic signed [PosW-1:0] d0;
		logic signed [PosW-1:0] d2;
		d0 = $signed({{(PosW-ByteW){1'b0}}, c0}) - 19'sd48;
		d2 = $signed({{(PosW-ByteW){1'b0}}, c2}) - 19'sd48;
		return d0 * 19'sd1000 + d2 * 19'sd100;
	endfunction

	// tens and units part: (c3-48)*10 + (c4-48)
	function automatic logic signed [LoW-1:0] lo_part(input logic [ByteW-1:0] c3,
			input logic [ByteW-1:0] c4);
		logic signed [LoW-1:0] d3;
		logic signed [LoW-1:0] d4;
		d3 = $signed({{(LoW-ByteW){1'b0}}, c3}) - 13'sd48;
		d4 = $signed({{(LoW-ByteW){1'b0}}, c4}) - 13'sd48;
		return d3 * 13'sd10 + d4;
	endfunction

endpackage

@@ hw/rtl/axfp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axfp_front
// Frame hunt and character capture; hands complete frames to the queue.
// ----------------------------------------------------------------------------
module axfp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [axfp_pkg::ByteW-1:0]          rx_byte,
	input  logic                                cfg_valid,
	input  logic [axfp_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [axfp_pkg::ByteW-1:0]          cfg_data,
	input  logic                                q_full,
	output axfp_pkg::push_t                     push
);

	axfp_pkg::phase_t               phase_q, phase_d;
	logic [axfp_pkg::IdxW-1:0]      idx_q, idx_d;
	logic [axfp_pkg::ByteW-1:0]     header_q;
	logic [axfp_pkg::ByteW-1:0]     trailer_q;
	logic [axfp_pkg::ByteW-1:0]     x_chars_q [axfp_pkg::GroupLen];
	logic [axfp_pkg::ByteW-1:0]     y_chars_q [axfp_pkg::GroupLen];
	logic                           beat;
	logic                           wr_x;
	logic                           wr_y;
	logic                           last_char;

	assign in_ready  = !q_full;
	assign beat      = in_valid && in_ready;
	assign last_char = (idx_q == axfp_pkg::IdxW'(axfp_pkg::GroupLen - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= axfp_pkg::HeaderReset;
			trailer_q <= axfp_pkg::TrailerReset;
		end else if (cfg_valid) begin
			if (cfg_index == axfp_pkg::CFG_HEADER) begin
				header_q <= cfg_data;
			end else begin
				trailer_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= axfp_pkg::PH_HUNT;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		idx_d        = idx_q;
		wr_x         = 1'b0;
		wr_y         = 1'b0;
		push.valid   = 1'b0;
		push.frame.x_dig = {x_chars_q[4], x_chars_q[3], x_chars_q[2], x_chars_q[0]};
		push.frame.y_dig = {y_chars_q[4], y_chars_q[3], y_chars_q[2], y_chars_q[0]};
		if (beat) begin
			case (phase_q)
				axfp_pkg::PH_HUNT: begin
					if (rx_byte == header_q) begin
						phase_d = axfp_pkg::PH_X;
					end
				end
				axfp_pkg::PH_X: begin
					wr_x  = 1'b1;
					idx_d = last_char ? '0 : idx_q + 1'b1;
					if (last_char) begin
						phase_d = axfp_pkg::PH_Y;
					end
				end
				axfp_pkg::PH_Y: begin
					wr_y  = 1'b1;
					idx_d = last_char ? '0 : idx_q + 1'b1;
					if (last_char) begin
						phase_d = axfp_pkg::PH_TRAIL;
					end
				end
				axfp_pkg::PH_TRAIL: begin
					// bad trailer drops the frame without a result
					push.valid = (rx_byte == trailer_q);
					phase_d    = axfp_pkg::PH_HUNT;
					idx_d      = '0;
				end
				default: begin
					phase_d = axfp_pkg::PH_HUNT;
					idx_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_x) begin
			x_chars_q[idx_q] <= rx_byte;
		end
		if (wr_y) begin
			y_chars_q[idx_q] <= rx_byte;
		end
	end

endmodule

@@ hw/rtl/axfp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axfp_queue
// Short frame queue between the parsing front and the decode back end.
// ----------------------------------------------------------------------------
module axfp_queue #(
	parameter int DEPTH = axfp_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  axfp_pkg::push_t  push,
	input  logic             pop,
	output logic             q_valid,
	output logic             q_full,
	output axfp_pkg::frame_t q_frame
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	axfp_pkg::frame_t  mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_pop;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == CntW'(DEPTH));
	assign q_frame = mem_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.frame;
		end
	end

endmodule

@@ hw/rtl/axfp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axfp_back
// Two-stage decimal decode of queued frames with a registered result beat.
// ----------------------------------------------------------------------------
module axfp_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  axfp_pkg::frame_t                     q_frame,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [axfp_pkg::PosW-1:0]     pos_x,
	output logic signed [axfp_pkg::PosW-1:0]     pos_y
);

	localparam int ExtW = axfp_pkg::PosW - axfp_pkg::LoW;

	logic                                valid_s1;
	logic signed [axfp_pkg::PosW-1:0]    x_hi_s1;
	logic signed [axfp_pkg::PosW-1:0]    y_hi_s1;
	logic signed [axfp_pkg::LoW-1:0]     x_lo_s1;
	logic signed [axfp_pkg::LoW-1:0]     y_lo_s1;
	logic                                out_valid_q;
	logic signed [axfp_pkg::PosW-1:0]    pos_x_q;
	logic signed [axfp_pkg::PosW-1:0]    pos_y_q;
	logic                                out_free;
	logic                                s1_load;

	assign out_free  = !out_valid_q || out_ready;
	assign s1_load   = !valid_s1 || out_free;
	assign pop       = s1_load && q_valid;
	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= q_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_hi_s1 <= axfp_pkg::hi_part(q_frame.x_dig[0], q_frame.x_dig[1]);
			x_lo_s1 <= axfp_pkg::lo_part(q_frame.x_dig[2], q_frame.x_dig[3]);
			y_hi_s1 <= axfp_pkg::hi_part(q_frame.y_dig[0], q_frame.y_dig[1]);
			y_lo_s1 <= axfp_pkg::lo_part(q_frame.y_dig[2], q_frame.y_dig[3]);
		end
		if (out_free && valid_s1) begin
			pos_x_q <= x_hi_s1 + {{ExtW{x_lo_s1[axfp_pkg::LoW-1]}}, x_lo_s1};
			pos_y_q <= y_hi_s1 + {{ExtW{y_lo_s1[axfp_pkg::LoW-1]}}, y_lo_s1};
		end
	end

endmodule

@@ hw/rtl/ascii_xy_frame_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_xy_frame_parser_unit
// Parses header / five x chars / five y chars / trailer frames into decimal x, y.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | in_valid / in_ready     | rx_byte (8b)
//  config   | cfg_valid / cfg_ready   | cfg_index (0 header, 1 trailer), cfg_data
//  result   | out_valid / out_ready   | pos_x, pos_y (19b signed)
//
// one rx_byte beat per cycle unless the queue is full; each byte steps the front
// a result beat follows the trailer beat through the queue head, the decode
// stage and the output register
// in_ready drops only when the frame queue is full, which needs a stalled result
// cfg_ready is always high; reset clears control state and loads 0xcc / 0xdd
//
module ascii_xy_frame_parser_unit #(
	parameter int QUEUE_DEPTH = axfp_pkg::QueueDepth
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [axfp_pkg::ByteW-1:0]           rx_byte,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [axfp_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [axfp_pkg::ByteW-1:0]           cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [axfp_pkg::PosW-1:0]     pos_x,
	output logic signed [axfp_pkg::PosW-1:0]     pos_y
);

	axfp_pkg::push_t  push;
	axfp_pkg::frame_t q_frame;
	logic             q_valid;
	logic             q_full;
	logic             pop;

	assign cfg_ready = 1'b1;

	axfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push)
	);

	axfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.q_valid (q_valid),
		.q_full  (q_full),
		.q_frame (q_frame)
	);

	axfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_frame   (q_frame),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y)
	);

endmodule

@@ hw/rtl/axfp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axfp_checker
// Port-level checks for the ascii xy frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module axfp_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [axfp_pkg::ByteW-1:0]           rx_byte,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [axfp_pkg::PosW-1:0]     pos_x,
	input  logic signed [axfp_pkg::PosW-1:0]     pos_y
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y))
		else $error("result payload changed while stalled");

	// a stalled input beat keeps its byte
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(rx_byte))
		else $error("input beat changed while stalled");

	// input backpressure only comes from a result that is not being taken
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !$past(out_ready))
		else $error("input stalled without a pending result");

	a_cfg_always: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config beat not taken");

endmodule

bind ascii_xy_frame_parser_unit axfp_checker u_axfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.rx_byte   (rx_byte),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pos_x     (pos_x),
	.pos_y     (pos_y)
);

@@ test/ascii_xy_frame_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_xy_frame_parser_unit_tb
// Self-checking bench for the ascii xy frame parser. Bytes are streamed in with
// random gaps, frames are decoded by a local position predictor, and every
// result beat is compared field by field with the oldest predicted position.
// Header and trailer registers are swept through several settings, extremes
// included, while the result side stalls at random.
// ----------------------------------------------------------------------------
module ascii_xy_frame_parser_unit_tb;

	localparam int AsciiZero    = 48;
	localparam int StallLimit   = 2000;
	localparam int SettlePause  = 6;
	localparam int BytesPerTest = 250;

	typedef struct {
		logic signed [axfp_pkg::PosW-1:0] x;
		logic signed [axfp_pkg::PosW-1:0] y;
	} xy_pos_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_ready;
	logic [axfp_pkg::ByteW-1:0]       rx_byte   = '0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [axfp_pkg::CfgIdxW-1:0]     cfg_index = axfp_pkg::CFG_HEADER;
	logic [axfp_pkg::ByteW-1:0]       cfg_data  = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic signed [axfp_pkg::PosW-1:0] pos_x;
	logic signed [axfp_pkg::PosW-1:0] pos_y;

	// predictor state
	logic [axfp_pkg::ByteW-1:0]                           hdr_reg;
	logic [axfp_pkg::ByteW-1:0]                           trl_reg;
	axfp_pkg::phase_t                                     ph;
	logic [axfp_pkg::IdxW-1:0]                            char_idx;
	logic [axfp_pkg::GroupLen-1:0][axfp_pkg::ByteW-1:0]   x_chars;
	logic [axfp_pkg::GroupLen-1:0][axfp_pkg::ByteW-1:0]   y_chars;

	xy_pos_t expected_pos[$];
	int      error_count  = 0;
	int      frame_bytes  = 0;
	int      in_burst     = 0;
	bit      in_idle_on   = 1'b1;

	ascii_xy_frame_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// chars 0, 2, 3, 4 weighted 1000/100/10/1, char 1 unused
	function automatic logic signed [axfp_pkg::PosW-1:0] decimal_value(
			input logic [axfp_pkg::GroupLen-1:0][axfp_pkg::ByteW-1:0] c);
		int v;
		v = (int'(c[0]) - AsciiZero) * 1000 + (int'(c[2]) - AsciiZero) * 100
			+ (int'(c[3]) - AsciiZero) * 10 + (int'(c[4]) - AsciiZero);
		return v[axfp_pkg::PosW-1:0];
	endfunction

	task automatic predict_byte(input logic [axfp_pkg::ByteW-1:0] b);
		xy_pos_t p;
		case (ph)
			axfp_pkg::PH_HUNT: begin
				if (b == hdr_reg) begin
					ph = axfp_pkg::PH_X;
					frame_bytes++;
				end
			end
			axfp_pkg::PH_X: begin
				x_chars[char_idx] = b;
				frame_bytes++;
				if (char_idx == axfp_pkg::GroupLen - 1) begin
					char_idx = '0;
					ph = axfp_pkg::PH_Y;
				end else begin
					char_idx++;
				end
			end
			axfp_pkg::PH_Y: begin
				y_chars[char_idx] = b;
				frame_bytes++;
				if (char_idx == axfp_pkg::GroupLen - 1) begin
					char_idx = '0;
					ph = axfp_pkg::PH_TRAIL;
				end else begin
					char_idx++;
				end
			end
			default: begin
				frame_bytes++;
				if (b == trl_reg) begin
					p.x = decimal_value(x_chars);
					p.y = decimal_value(y_chars);
					expected_pos.push_back(p);
				end
				ph = axfp_pkg::PH_HUNT;
				char_idx = '0;
			end
		endcase
	endtask

	task automatic send_byte(input logic [axfp_pkg::ByteW-1:0] b);
		int gap;
		if (in_burst == 0) begin
			in_burst = $urandom_range(20, 80);
			in_idle_on = ($urandom_range(0, 2) != 0);
		end
		in_burst--;
		gap = in_idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
	endtask

	// lowers valid and lets every predicted position come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_pos.size() != 0);
	endtask

	task automatic program_reg(input axfp_pkg::cfg_reg_t r,
			input logic [axfp_pkg::ByteW-1:0] v);
		wait_drained();
		// a frame without a result may still be in flight
		repeat (SettlePause) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (r == axfp_pkg::CFG_HEADER)
			hdr_reg = v;
		else
			trl_reg = v;
	endtask

	function automatic logic [axfp_pkg::ByteW-1:0] rand_char();
		logic [axfp_pkg::ByteW-1:0] c;
		if ($urandom_range(0, 9) < 6)
			c = axfp_pkg::ByteW'(AsciiZero + $urandom_range(0, 9));
		else
			c = axfp_pkg::ByteW'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic send_frame(input bit well_formed);
		int n_noise;
		int n_chars;
		logic [axfp_pkg::ByteW-1:0] b;
		n_noise = $urandom_range(0, 2);
		repeat (n_noise) begin
			b = axfp_pkg::ByteW'($urandom_range(0, 255));
			send_byte(b);
		end
		send_byte(hdr_reg);
		n_chars = well_formed ? 2 * axfp_pkg::GroupLen
			: $urandom_range(0, 2 * axfp_pkg::GroupLen);
		repeat (n_chars) send_byte(rand_char());
		if (n_chars == 2 * axfp_pkg::GroupLen) begin
			b = axfp_pkg::ByteW'($urandom_range(0, 255));
			if (well_formed && $urandom_range(0, 6) != 0)
				b = trl_reg;
			send_byte(b);
		end
	endtask

	task automatic random_frames(input int target);
		int start;
		int n_frames;
		start = frame_bytes;
		n_frames = 0;
		while (frame_bytes - start < target) begin
			send_frame($urandom_range(0, 4) != 0);
			n_frames++;
			// every tenth frame the sender holds off until the result side has caught up
			if (n_frames % 10 == 0)
				wait_drained();
		end
	endtask

	// extremes of the characters, header inside a frame, bad trailer
	task automatic test_directed_frames();
		send_byte(8'h00);
		send_byte(hdr_reg);
		repeat (axfp_pkg::GroupLen) send_byte(8'h00);
		repeat (axfp_pkg::GroupLen) send_byte(8'hFF);
		send_byte(trl_reg);
		send_byte(hdr_reg);
		send_byte("9");
		send_byte("7");
		send_byte("9");
		send_byte("9");
		send_byte("9");
		send_byte(hdr_reg);
		send_byte("0");
		send_byte("0");
		send_byte("0");
		send_byte("1");
		send_byte(~trl_reg);
		wait_drained();
	endtask

	task automatic test_default_regs();
		random_frames(BytesPerTest);
	endtask

	task automatic test_extreme_regs();
		program_reg(axfp_pkg::CFG_HEADER, 8'h00);
		program_reg(axfp_pkg::CFG_TRAILER, 8'hFF);
		random_frames(BytesPerTest);
		program_reg(axfp_pkg::CFG_HEADER, 8'hFF);
		program_reg(axfp_pkg::CFG_TRAILER, 8'h00);
		random_frames(BytesPerTest);
	endtask

	task automatic test_equal_regs();
		logic [axfp_pkg::ByteW-1:0] v;
		v = axfp_pkg::ByteW'($urandom_range(0, 255));
		program_reg(axfp_pkg::CFG_HEADER, v);
		program_reg(axfp_pkg::CFG_TRAILER, v);
		random_frames(BytesPerTest);
	endtask

	task automatic test_random_regs();
		logic [axfp_pkg::ByteW-1:0] h;
		logic [axfp_pkg::ByteW-1:0] t;
		h = axfp_pkg::ByteW'($urandom_range(0, 255));
		t = axfp_pkg::ByteW'($urandom_range(0, 255));
		program_reg(axfp_pkg::CFG_TRAILER, t);
		program_reg(axfp_pkg::CFG_HEADER, h);
		random_frames(BytesPerTest);
	endtask

	// result side: random stalls per beat, compared with the oldest prediction
	initial begin
		int stall;
		int out_burst;
		bit out_idle_on;
		xy_pos_t exp_pos;
		out_burst = 0;
		out_idle_on = 1'b1;
		wait (arst_n);
		forever begin
			if (out_burst == 0) begin
				out_burst = $urandom_range(3, 10);
				out_idle_on = ($urandom_range(0, 2) != 0);
			end
			out_burst--;
			stall = out_idle_on ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_pos.size() == 0) begin
				report_error($sformatf("result beat with nothing expected: x=%0d y=%0d",
					pos_x, pos_y));
			end else begin
				exp_pos = expected_pos.pop_front();
				if (pos_x !== exp_pos.x)
					report_error($sformatf("pos_x got %0d expected %0d", pos_x, exp_pos.x));
				if (pos_y !== exp_pos.y)
					report_error($sformatf("pos_y got %0d expected %0d", pos_y, exp_pos.y));
			end
		end
	end

	// watchdog on cycles without any accepted beat
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < StallLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		hdr_reg  = axfp_pkg::HeaderReset;
		trl_reg  = axfp_pkg::TrailerReset;
		ph       = axfp_pkg::PH_HUNT;
		char_idx = '0;
		x_chars  = '0;
		y_chars  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_default_regs();
		test_extreme_regs();
		test_equal_regs();
		test_random_regs();

		wait_drained();
		repeat (SettlePause + 2) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
